### src/dqts_pkg.sv
// ============================================================================
// dqts_pkg
// shared types and constants for the delta queue task scheduler
// ============================================================================
package dqts_pkg;

    localparam int DEF_MAX_TASKS = 16;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ADD      = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_HEAD,
        ST_DROP,
        ST_INS,
        ST_WALK,
        ST_SHIFT,
        ST_FIX,
        ST_NEW,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [7:0]  tid;
        logic [31:0] delta;
        logic [31:0] period;
        logic [7:0]  pending;
    } entry_t;

    typedef struct packed {
        logic [4:0] queued;
        logic [4:0] position;
        logic       accepted;
        logic [7:0] run_task;
        logic       ran;
    } result_t;

endpackage

### src/dqts_mem.sv
// ============================================================================
// dqts_mem
// task entry memory, one write and one registered read port
// ============================================================================
module dqts_mem #(
    parameter int DEPTH = dqts_pkg::DEF_MAX_TASKS,
    parameter int AW    = $clog2(dqts_pkg::DEF_MAX_TASKS)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  dqts_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output dqts_pkg::entry_t rdata
);
    import dqts_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/dqts_ctrl.sv
// ============================================================================
// dqts_ctrl
// sequencer for tick, add and dispatch over the entry memory
// ============================================================================
module dqts_ctrl #(
    parameter int MAX_TASKS = dqts_pkg::DEF_MAX_TASKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_op,
    input  logic [7:0]                    in_task,
    input  logic [31:0]                   in_delay,
    input  logic [31:0]                   in_period,
    output logic                          res_valid,
    input  logic                          res_ready,
    output dqts_pkg::result_t             res,
    output logic [$clog2(MAX_TASKS)-1:0]  mem_raddr,
    input  dqts_pkg::entry_t              mem_rdata,
    output logic                          mem_we,
    output logic [$clog2(MAX_TASKS)-1:0]  mem_waddr,
    output dqts_pkg::entry_t              mem_wdata
);
    import dqts_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int XW = CW + 1;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [IW-1:0] k_reg, k_next;
    logic          add_reg, add_next;
    logic [1:0]    op_reg, op_next;
    logic [7:0]    id_reg, id_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   period_reg, period_next;
    entry_t        stop_reg, stop_next;
    logic          ran_reg, ran_next;
    logic [7:0]    run_reg, run_next;
    logic          acc_reg, acc_next;

    logic [XW-1:0] cnt_x, slot_x, k_x;
    logic [IW-1:0] cnt_i;
    logic          walk_le, walk_last, walk_move, drop_more, shift_more;
    logic          head_due, list_full;
    entry_t        tick_entry, fix_entry, new_entry;

    assign cnt_x      = XW'(count_reg);
    assign slot_x     = XW'(slot_reg);
    assign k_x        = XW'(k_reg);
    assign cnt_i      = IW'(count_reg);
    assign walk_le    = mem_rdata.delta <= rem_reg;
    assign walk_last  = (slot_x + XW'(1)) == cnt_x;
    assign walk_move  = (slot_x + XW'(1)) < cnt_x;
    assign drop_more  = (k_x + XW'(1)) < cnt_x;
    assign shift_more = k_x > (slot_x + XW'(2));
    assign head_due   = mem_rdata.pending != 8'd0;
    assign list_full  = cnt_x >= XW'(MAX_TASKS);

    // head update on a tick
    always_comb
    begin
        tick_entry = mem_rdata;
        if (mem_rdata.delta == 32'd0)
        begin
            if (mem_rdata.pending != 8'hFF)
            begin
                tick_entry.pending = mem_rdata.pending + 8'd1;
            end
            if (mem_rdata.period != 32'd0)
            begin
                tick_entry.delta = mem_rdata.period;
            end
        end
        else
        begin
            tick_entry.delta = mem_rdata.delta - 32'd1;
        end
    end

    always_comb
    begin
        fix_entry       = stop_reg;
        fix_entry.delta = stop_reg.delta - rem_reg;
        new_entry       = '{tid: id_reg, delta: rem_reg, period: period_reg, pending: 8'd0};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (op_reg)
                    OP_TICK, OP_DISPATCH: state_next = (count_reg != '0) ? ST_HEAD : ST_RESP;
                    OP_ADD:               state_next = list_full ? ST_RESP : ST_INS;
                    default:              state_next = ST_RESP;
                endcase
            end
            ST_HEAD:
            begin
                if (op_reg == OP_DISPATCH && head_due)
                begin
                    if (cnt_x >= XW'(2))
                    begin
                        state_next = ST_DROP;
                    end
                    else if (mem_rdata.period != 32'd0)
                    begin
                        state_next = ST_INS;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DROP:
            begin
                if (!drop_more)
                begin
                    state_next = (period_reg != 32'd0) ? ST_INS : ST_RESP;
                end
            end
            ST_INS:
            begin
                state_next = (count_reg == '0) ? ST_NEW : ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_le)
                begin
                    if (walk_last)
                    begin
                        state_next = ST_NEW;
                    end
                end
                else
                begin
                    state_next = walk_move ? ST_SHIFT : ST_FIX;
                end
            end
            ST_SHIFT:
            begin
                if (!shift_more)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:  state_next = ST_NEW;
            ST_NEW:  state_next = ST_RESP;
            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory port and handshake outputs
    always_comb
    begin
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = mem_rdata;
        case (state_reg)
            ST_HEAD:
            begin
                if (op_reg == OP_TICK)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = tick_entry;
                end
                else
                begin
                    mem_raddr = IW'(1);
                end
            end
            ST_DROP:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg;
                mem_raddr = k_reg + IW'(2);
            end
            ST_WALK:
            begin
                mem_raddr = walk_le ? (slot_reg + IW'(1)) : (cnt_i - IW'(1));
            end
            ST_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg;
                mem_raddr = k_reg - IW'(2);
            end
            ST_FIX:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg + IW'(1);
                mem_wdata = fix_entry;
            end
            ST_NEW:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = new_entry;
            end
            default:
            begin
                mem_raddr = '0;
            end
        endcase
    end

    assign in_ready     = state_reg == ST_IDLE;
    assign res_valid    = state_reg == ST_RESP;
    assign res.ran      = ran_reg;
    assign res.run_task = run_reg;
    assign res.accepted = acc_reg;
    assign res.position = acc_reg ? 5'(slot_reg) : 5'd0;
    assign res.queued   = 5'(count_reg);

    // datapath
    always_comb
    begin
        count_next  = count_reg;
        slot_next   = slot_reg;
        k_next      = k_reg;
        add_next    = add_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        rem_next    = rem_reg;
        period_next = period_reg;
        stop_next   = stop_reg;
        ran_next    = ran_reg;
        run_next    = run_reg;
        acc_next    = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                op_next     = in_op;
                id_next     = in_task;
                rem_next    = in_delay;
                period_next = in_period;
            end
            ST_DECODE:
            begin
                add_next = op_reg == OP_ADD;
                ran_next = 1'b0;
                run_next = 8'd0;
                acc_next = 1'b0;
            end
            ST_HEAD:
            begin
                if (op_reg == OP_DISPATCH && head_due)
                begin
                    ran_next    = 1'b1;
                    run_next    = mem_rdata.tid;
                    id_next     = mem_rdata.tid;
                    rem_next    = mem_rdata.delta;
                    period_next = mem_rdata.period;
                    add_next    = 1'b0;
                    count_next  = count_reg - CW'(1);
                    k_next      = '0;
                end
            end
            ST_DROP:
            begin
                k_next = k_reg + IW'(1);
            end
            ST_INS:
            begin
                slot_next = '0;
            end
            ST_WALK:
            begin
                if (walk_le)
                begin
                    rem_next  = rem_reg - mem_rdata.delta;
                    slot_next = slot_reg + IW'(1);
                end
                else
                begin
                    stop_next = mem_rdata;
                    k_next    = cnt_i;
                end
            end
            ST_SHIFT:
            begin
                k_next = k_reg - IW'(1);
            end
            ST_NEW:
            begin
                count_next = count_reg + CW'(1);
                acc_next   = add_reg;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        k_reg      <= k_next;
        add_reg    <= add_next;
        op_reg     <= op_next;
        id_reg     <= id_next;
        rem_reg    <= rem_next;
        period_reg <= period_next;
        stop_reg   <= stop_next;
        ran_reg    <= ran_next;
        run_reg    <= run_next;
        acc_reg    <= acc_next;
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_x <= XW'(MAX_TASKS))
        else $error("task count above capacity");

    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NEW |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list");

    a_new_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NEW |-> slot_x <= cnt_x && !list_full)
        else $error("insert slot beyond list end");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT |-> k_x >= slot_x + XW'(2) && k_x <= cnt_x)
        else $error("shift write outside moved range");

    a_res_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.ran && res.accepted))
        else $error("dispatch and add reported together");
`endif

endmodule

### src/delta_queue_task_scheduler.sv
// ============================================================================
// delta_queue_task_scheduler
// delta list timer queue with tick, add and dispatch operations
// ============================================================================
//  channel | dir | tdata (low bit up)                          | tuser
//  s_*     | in  | task_id[7:0] delay_ticks[39:8]              | op[1:0]
//          |     | period_ticks[71:40]                         |
//  m_*     | out | ran[0] run_task[8:1] accepted[9]            | -
//          |     | position[14:10] queued[19:15]               |
//
//  tick: decode, head update when tasks are queued, response; no-op: decode, response
//  add: insert, walk, shift, fix, new; dispatch of a periodic head: drop then reinsert
//  the entry memory has one read and one write port, so each operation steps through states
//  rst_n clears the sequencer and the task count; entry memory is not cleared
//  a finished result waits in the output register while the next transaction is taken
// ============================================================================
module delta_queue_task_scheduler #(
    parameter int MAX_TASKS = dqts_pkg::DEF_MAX_TASKS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // task_id, delay_ticks, period_ticks
    input  logic [1:0]  s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // ran, run_task, accepted, position, queued
);
    import dqts_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);

    logic          res_valid, res_ready;
    result_t       res;
    logic [IW-1:0] mem_raddr, mem_waddr;
    logic          mem_we;
    entry_t        mem_rdata, mem_wdata;

    logic          out_valid_reg, out_valid_next;
    logic [23:0]   out_data_reg, out_data_next;

    dqts_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_task   (s_tdata[7:0]),
        .in_delay  (s_tdata[39:8]),
        .in_period (s_tdata[71:40]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    dqts_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {4'd0, res.queued, res.position, res.accepted,
                              res.run_task, res.ran};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
